@@ design/llqm_pkg.sv @@
`timescale 1ns / 1ps

package llqm_pkg;

  // Default pool geometry
  localparam int NODE_COUNT_DEF  = 16;
  localparam int QUEUE_COUNT_DEF = 4;

  // Fixed port field widths
  localparam int REQ_W       = 2;
  localparam int NODE_IDX_W  = 4;
  localparam int QUEUE_IDX_W = 2;
  localparam int STATUS_W    = 2;

  typedef enum logic [REQ_W-1:0] {
    REQ_PUSH   = 2'd0,
    REQ_REMOVE = 2'd1,
    REQ_POP    = 2'd2
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_REJECTED = 2'd1,
    ST_EMPTY    = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_PUSH_TAIL,
    S_PUSH_AFTER,
    S_PUSH_LINK,
    S_POP_HEAD,
    S_UNLINK_LINK,
    S_UNLINK_SELF,
    S_DONE
  } ctrl_state_e;

  // Datapath commands, one per cycle
  typedef enum logic [3:0] {
    OP_NONE,
    OP_CLEAR,
    OP_CAPTURE,
    OP_DISPATCH,
    OP_PUSH_TAIL,
    OP_PUSH_AFTER,
    OP_PUSH_LINK,
    OP_POP_HEAD,
    OP_UNLINK_LINK,
    OP_UNLINK_SELF,
    OP_LOAD_OUT
  } dp_op_e;

  typedef struct packed {
    logic clr_last;
    logic out_free;
    logic owned;
    logic head_empty;
    logic in_range;
    req_e req;
  } dp_status_t;

endpackage

@@ design/llqm_ctrl.sv @@
`timescale 1ns / 1ps

module llqm_ctrl
  import llqm_pkg::*;
(
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_ready_o,
  input  dp_status_t stat_i,
  output dp_op_e     op_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: begin
        if (stat_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (in_valid_i) state_d = S_DISPATCH;
      end
      S_DISPATCH: begin
        if (!stat_i.in_range) begin
          state_d = S_DONE;
        end else begin
          unique case (stat_i.req)
            REQ_PUSH:   state_d = stat_i.owned ? S_DONE : S_PUSH_TAIL;
            REQ_REMOVE: state_d = S_UNLINK_LINK;
            REQ_POP:    state_d = S_POP_HEAD;
            default:    state_d = S_DONE;
          endcase
        end
      end
      S_PUSH_TAIL:   state_d = S_PUSH_AFTER;
      S_PUSH_AFTER:  state_d = S_PUSH_LINK;
      S_PUSH_LINK:   state_d = S_DONE;
      S_POP_HEAD: begin
        state_d = stat_i.head_empty ? S_DONE : S_UNLINK_LINK;
      end
      S_UNLINK_LINK: state_d = S_UNLINK_SELF;
      S_UNLINK_SELF: state_d = S_DONE;
      S_DONE: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      default:       state_d = S_CLEAR;
    endcase
  end

  // Outputs
  always_comb begin
    in_ready_o = 1'b0;
    op_o       = OP_NONE;
    unique case (state_q)
      S_CLEAR: op_o = OP_CLEAR;
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) op_o = OP_CAPTURE;
      end
      S_DISPATCH:    op_o = OP_DISPATCH;
      S_PUSH_TAIL:   op_o = OP_PUSH_TAIL;
      S_PUSH_AFTER:  op_o = OP_PUSH_AFTER;
      S_PUSH_LINK:   op_o = OP_PUSH_LINK;
      S_POP_HEAD:    op_o = OP_POP_HEAD;
      S_UNLINK_LINK: op_o = OP_UNLINK_LINK;
      S_UNLINK_SELF: op_o = OP_UNLINK_SELF;
      S_DONE: begin
        if (stat_i.out_free) op_o = OP_LOAD_OUT;
      end
      default:       op_o = OP_NONE;
    endcase
  end

endmodule

@@ design/llqm_datapath.sv @@
`timescale 1ns / 1ps

module llqm_datapath
  import llqm_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dp_op_e                 op_i,
  output dp_status_t             stat_o,
  input  logic [REQ_W-1:0]       req_type_i,
  input  logic [NODE_IDX_W-1:0]  node_index_i,
  input  logic [QUEUE_IDX_W-1:0] queue_index_i,
  input  logic                   out_ready_i,
  output logic                   out_valid_o,
  output logic [STATUS_W-1:0]    status_o,
  output logic [NODE_IDX_W-1:0]  result_node_o,
  output logic                   node_valid_o
);

  localparam int LINK_TOTAL = NODE_COUNT + QUEUE_COUNT;
  localparam int LINK_W     = $clog2(LINK_TOTAL);
  localparam int NODE_W     = $clog2(NODE_COUNT);
  localparam int OWN_W      = $clog2(QUEUE_COUNT + 1);
  localparam logic [LINK_W-1:0] SENT_BASE = LINK_W'(NODE_COUNT);
  localparam logic [LINK_W-1:0] CLR_LAST  = LINK_W'(LINK_TOTAL - 1);

  // Link and owner stores
  logic [LINK_W-1:0] next_mem [LINK_TOTAL];
  logic [LINK_W-1:0] prev_mem [LINK_TOTAL];
  logic [OWN_W-1:0]  own_mem  [NODE_COUNT];

  logic [LINK_W-1:0] next_raddr, prev_raddr, next_waddr, prev_waddr;
  logic [LINK_W-1:0] next_wdata, prev_wdata;
  logic              next_we, prev_we, own_we;
  logic [NODE_W-1:0] own_waddr;
  logic [OWN_W-1:0]  own_wdata;
  logic [LINK_W-1:0] next_rdata_q, prev_rdata_q;
  logic [OWN_W-1:0]  own_rdata_q;

  // Captured request and work registers
  req_e                   req_q;
  logic [NODE_IDX_W-1:0]  node_q;
  logic [QUEUE_IDX_W-1:0] queue_q;
  logic [LINK_W-1:0]      a_q, b_q, v_q;
  logic [LINK_W-1:0]      clr_q;
  status_e                res_status_q;
  logic [NODE_IDX_W-1:0]  res_node_q;
  logic                   res_valid_q;

  // Output register
  logic                   out_valid_q;
  status_e                out_status_q;
  logic [NODE_IDX_W-1:0]  out_node_q;
  logic                   out_nvalid_q;

  logic              node_ok, queue_ok, in_range, head_empty, owned, out_free;
  logic [LINK_W-1:0] node_link, sent;

  assign node_ok    = 32'(node_q) < NODE_COUNT;
  assign queue_ok   = 32'(queue_q) < QUEUE_COUNT;
  assign node_link  = LINK_W'(node_q);
  assign sent       = SENT_BASE + LINK_W'(queue_q);
  assign head_empty = 32'(next_rdata_q) >= NODE_COUNT;
  assign owned      = own_rdata_q != '0;
  assign out_free   = !out_valid_q || out_ready_i;

  always_comb begin
    unique case (req_q)
      REQ_PUSH:   in_range = node_ok && queue_ok;
      REQ_REMOVE: in_range = node_ok;
      REQ_POP:    in_range = queue_ok;
      default:    in_range = 1'b0;
    endcase
  end

  assign stat_o = '{clr_last:   (clr_q == CLR_LAST),
                    out_free:   out_free,
                    owned:      owned,
                    head_empty: head_empty,
                    in_range:   in_range,
                    req:        req_q};

  // Store address and write selection
  always_comb begin
    next_raddr = '0;
    prev_raddr = '0;
    next_we    = 1'b0;
    prev_we    = 1'b0;
    own_we     = 1'b0;
    next_waddr = '0;
    prev_waddr = '0;
    next_wdata = '0;
    prev_wdata = '0;
    own_waddr  = '0;
    own_wdata  = '0;
    unique case (op_i)
      OP_CLEAR: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = clr_q;
        prev_waddr = clr_q;
        next_wdata = clr_q;
        prev_wdata = clr_q;
        own_we     = 32'(clr_q) < NODE_COUNT;
        own_waddr  = NODE_W'(clr_q);
      end
      OP_DISPATCH: begin
        next_raddr = (req_q == REQ_POP) ? sent : node_link;
        prev_raddr = (req_q == REQ_PUSH) ? sent : node_link;
      end
      OP_PUSH_TAIL: begin
        next_raddr = prev_rdata_q;
      end
      OP_PUSH_AFTER: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = node_link;
        prev_waddr = node_link;
        next_wdata = next_rdata_q;
        prev_wdata = a_q;
      end
      OP_PUSH_LINK: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = a_q;
        prev_waddr = b_q;
        next_wdata = node_link;
        prev_wdata = node_link;
        own_we     = 1'b1;
        own_waddr  = NODE_W'(node_q);
        own_wdata  = OWN_W'(queue_q) + OWN_W'(1);
      end
      OP_POP_HEAD: begin
        next_raddr = next_rdata_q;
        prev_raddr = next_rdata_q;
      end
      OP_UNLINK_LINK: begin
        // splice neighbors around the victim
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = prev_rdata_q;
        prev_waddr = next_rdata_q;
        next_wdata = next_rdata_q;
        prev_wdata = prev_rdata_q;
      end
      OP_UNLINK_SELF: begin
        next_we    = 1'b1;
        prev_we    = 1'b1;
        next_waddr = v_q;
        prev_waddr = v_q;
        next_wdata = v_q;
        prev_wdata = v_q;
        own_we     = 1'b1;
        own_waddr  = NODE_W'(v_q);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (next_we) next_mem[next_waddr] <= next_wdata;
    if (prev_we) prev_mem[prev_waddr] <= prev_wdata;
    if (own_we)  own_mem[own_waddr]   <= own_wdata;
    next_rdata_q <= next_mem[next_raddr];
    prev_rdata_q <= prev_mem[prev_raddr];
    own_rdata_q  <= own_mem[NODE_W'(node_index_i)];
  end

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (op_i == OP_CLEAR) clr_q <= clr_q + LINK_W'(1);
      if (op_i == OP_LOAD_OUT) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    unique case (op_i)
      OP_CAPTURE: begin
        req_q   <= req_e'(req_type_i);
        node_q  <= node_index_i;
        queue_q <= queue_index_i;
      end
      OP_DISPATCH: begin
        res_status_q <= ST_DONE;
        res_node_q   <= '0;
        res_valid_q  <= 1'b0;
        v_q          <= node_link;
        if (req_q == REQ_REMOVE && node_ok) begin
          res_node_q  <= node_q;
          res_valid_q <= 1'b1;
        end
        if (req_q == REQ_PUSH && in_range && owned) res_status_q <= ST_REJECTED;
      end
      OP_PUSH_TAIL:  a_q <= prev_rdata_q;
      OP_PUSH_AFTER: b_q <= next_rdata_q;
      OP_POP_HEAD: begin
        if (head_empty) begin
          res_status_q <= ST_EMPTY;
        end else begin
          res_node_q  <= NODE_IDX_W'(next_rdata_q);
          res_valid_q <= 1'b1;
          v_q         <= next_rdata_q;
        end
      end
      OP_LOAD_OUT: begin
        out_status_q <= res_status_q;
        out_node_q   <= res_node_q;
        out_nvalid_q <= res_valid_q;
      end
      default: begin
      end
    endcase
  end

  assign out_valid_o   = out_valid_q;
  assign status_o      = out_status_q;
  assign result_node_o = out_node_q;
  assign node_valid_o  = out_nvalid_q;

  a_load_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_LOAD_OUT |-> out_free)
    else $error("result loaded over an untaken word");

  a_after_tail: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_PUSH_AFTER |-> $past(op_i) == OP_PUSH_TAIL)
    else $error("push link write without tail read");

  a_victim_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    op_i == OP_UNLINK_SELF |-> 32'(v_q) < NODE_COUNT)
    else $error("unlink target is a sentinel");

  a_fail_no_node: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && out_status_q != ST_DONE |-> !out_nvalid_q)
    else $error("failed request returns a node");

endmodule

@@ design/linked_list_queue_manager_top.sv @@
`timescale 1ns / 1ps

// Channel  Handshake                  Payload
// in       in_valid_i / in_ready_o    req_type_i, node_index_i, queue_index_i
// out      out_valid_o / out_ready_i  status_o, result_node_o, node_valid_o
//
// One word at a time: a word is taken only once the one before has walked its
// steps, which follow the chain of dependent reads through the registered
// link stores (one read and one write per store and cycle).
// After reset a clearing pass over all NODE_COUNT + QUEUE_COUNT entries links
// every entry to itself; no word is taken during it.
// A finished result sits in the output register; the next word is accepted
// while it waits, and only the final load of that word stalls on out_ready_i.

module linked_list_queue_manager_top
  import llqm_pkg::*;
#(
  parameter int NODE_COUNT  = NODE_COUNT_DEF,
  parameter int QUEUE_COUNT = QUEUE_COUNT_DEF
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   in_valid_i,
  output logic                   in_ready_o,
  input  logic [REQ_W-1:0]       req_type_i,
  input  logic [NODE_IDX_W-1:0]  node_index_i,
  input  logic [QUEUE_IDX_W-1:0] queue_index_i,
  output logic                   out_valid_o,
  input  logic                   out_ready_i,
  output logic [STATUS_W-1:0]    status_o,
  output logic [NODE_IDX_W-1:0]  result_node_o,
  output logic                   node_valid_o
);

  // Controller drives one command per cycle; datapath reports back
  dp_op_e     op;
  dp_status_t stat;

  llqm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .stat_i     (stat),
    .op_o       (op)
  );

  llqm_datapath #(
    .NODE_COUNT  (NODE_COUNT),
    .QUEUE_COUNT (QUEUE_COUNT)
  ) u_datapath (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .op_i          (op),
    .stat_o        (stat),
    .req_type_i    (req_type_i),
    .node_index_i  (node_index_i),
    .queue_index_i (queue_index_i),
    .out_ready_i   (out_ready_i),
    .out_valid_o   (out_valid_o),
    .status_o      (status_o),
    .result_node_o (result_node_o),
    .node_valid_o  (node_valid_o)
  );

endmodule

@@ tb/linked_list_queue_manager_top_tb.sv @@
`timescale 1ns / 1ps

module linked_list_queue_manager_top_tb;
  import llqm_pkg::*;

  // Pool geometry as built into the block under test
  localparam int NODES      = NODE_COUNT_DEF;
  localparam int QUEUES     = QUEUE_COUNT_DEF;
  localparam int LINKS      = NODES + QUEUES;
  localparam int LINK_W     = $clog2(LINKS);
  localparam int RAND_WORDS = 1700;
  // Worst stall: the longest drawn sender gap, the longest word through the block,
  // the longest drawn receiver stall, plus the clearing pass after reset. Take it many times over.
  localparam int IDLE_LIMIT = 4000;

  // The request code the block leaves unused
  localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]       req;
    logic [NODE_IDX_W-1:0]  node;
    logic [QUEUE_IDX_W-1:0] queue;
  } request_t;

  typedef struct packed {
    status_e               status;
    logic [NODE_IDX_W-1:0] node;
    logic                  node_ok;
  } outcome_t;

  logic                   clk_i         = 1'b0;
  logic                   rst_ni        = 1'b0;
  logic                   in_valid      = 1'b0;
  logic                   in_ready;
  logic [REQ_W-1:0]       req_type      = '0;
  logic [NODE_IDX_W-1:0]  node_index    = '0;
  logic [QUEUE_IDX_W-1:0] queue_index   = '0;
  logic                   out_valid;
  logic                   out_ready     = 1'b0;
  logic [STATUS_W-1:0]    status;
  logic [NODE_IDX_W-1:0]  result_node;
  logic                   node_valid;

  request_t pending_words[$];
  outcome_t expected_outcomes[$];
  int       error_count = 0;
  int       idle_cycles = 0;
  int       in_wait     = 0;
  int       out_stall   = 0;
  bit       no_idle     = 1'b0;

  // Shadow copy of the link store and the owner table
  logic [LINK_W-1:0] next_lk [LINKS];
  logic [LINK_W-1:0] prev_lk [LINKS];
  logic [2:0]        owner   [NODES];

  linked_list_queue_manager_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_ready_o    (in_ready),
    .req_type_i    (req_type),
    .node_index_i  (node_index),
    .queue_index_i (queue_index),
    .out_valid_o   (out_valid),
    .out_ready_i   (out_ready),
    .status_o      (status),
    .result_node_o (result_node),
    .node_valid_o  (node_valid)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // Every entry links to itself after reset; nothing is owned.
  initial begin
    for (int i = 0; i < LINKS; i++) begin
      next_lk[i] = LINK_W'(i);
      prev_lk[i] = LINK_W'(i);
    end
    for (int i = 0; i < NODES; i++) begin
      owner[i] = '0;
    end
  end

  // Detach one pool node from whatever ring holds it; a lone node just
  // re-links to itself.
  function automatic void detach_node(logic [LINK_W-1:0] n);
    logic [LINK_W-1:0] nx;
    logic [LINK_W-1:0] pv;
    nx = next_lk[n];
    pv = prev_lk[n];
    next_lk[pv] = nx;
    prev_lk[nx] = pv;
    next_lk[n]  = n;
    prev_lk[n]  = n;
    owner[n]    = '0;
  endfunction

  // Apply one accepted word to the shadow store and return what the block
  // must answer.
  function automatic outcome_t apply_request(request_t r);
    outcome_t          o;
    logic [LINK_W-1:0] n;
    logic [LINK_W-1:0] sent;
    logic [LINK_W-1:0] tail;
    logic [LINK_W-1:0] after;
    logic [LINK_W-1:0] head;
    o.status  = ST_DONE;
    o.node    = '0;
    o.node_ok = 1'b0;
    n    = LINK_W'(r.node);
    sent = LINK_W'(NODES + r.queue);
    case (r.req)
      REQ_PUSH: begin
        if (owner[n] != '0) begin
          o.status = ST_REJECTED;
        end else begin
          tail        = prev_lk[sent];
          after       = next_lk[tail];
          next_lk[n]  = after;
          prev_lk[n]  = tail;
          next_lk[tail] = n;
          prev_lk[after] = n;
          owner[n]    = 3'(r.queue) + 3'd1;
        end
      end
      REQ_REMOVE: begin
        detach_node(n);
        o.node    = r.node;
        o.node_ok = 1'b1;
      end
      REQ_POP: begin
        head = next_lk[sent];
        if (head >= LINK_W'(NODES)) begin
          o.status = ST_EMPTY;
        end else begin
          detach_node(head);
          o.node    = NODE_IDX_W'(head);
          o.node_ok = 1'b1;
        end
      end
      default: begin
      end
    endcase
    return o;
  endfunction

  function automatic void add_word(logic [REQ_W-1:0] req, int node, int queue);
    request_t r;
    r.req   = req;
    r.node  = NODE_IDX_W'(node);
    r.queue = QUEUE_IDX_W'(queue);
    pending_words.push_back(r);
  endfunction

  // Driver: hold the word until it is taken, then wait out the drawn gap.
  // Prediction happens at the accepting edge, so it follows the block's order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid    <= 1'b0;
      req_type    <= '0;
      node_index  <= '0;
      queue_index <= '0;
      in_wait     <= 0;
    end else begin
      if (in_valid && in_ready) begin
        expected_outcomes.push_back(apply_request({req_type, node_index, queue_index}));
      end
      if (!in_valid || in_ready) begin
        if (in_wait > 0) begin
          in_wait  <= in_wait - 1;
          in_valid <= 1'b0;
        end else if (pending_words.size() > 0) begin
          request_t r;
          r = pending_words.pop_front();
          req_type    <= r.req;
          node_index  <= r.node;
          queue_index <= r.queue;
          in_valid    <= 1'b1;
          in_wait     <= no_idle ? 0 : $urandom_range(0, 9);
          // Flip now and then between idling and back-to-back stretches
          if ($urandom_range(0, 39) == 0) begin
            no_idle <= !no_idle;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each taken result against the oldest expectation, then
  // drop ready for the drawn stall.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_ready <= 1'b0;
      out_stall <= 0;
    end else if (out_valid && out_ready) begin
      int stall;
      stall = no_idle ? 0 : $urandom_range(0, 9);
      if (expected_outcomes.size() == 0) begin
        $error("result word with nothing expected: status %0d node %0d valid %0d",
               status, result_node, node_valid);
        error_count++;
      end else begin
        outcome_t e;
        e = expected_outcomes.pop_front();
        if (status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, status);
          error_count++;
        end
        if (result_node !== e.node) begin
          $error("result_node: expected %0d, got %0d", e.node, result_node);
          error_count++;
        end
        if (node_valid !== e.node_ok) begin
          $error("node_valid: expected %0d, got %0d", e.node_ok, node_valid);
          error_count++;
        end
      end
      out_stall <= stall;
      out_ready <= (stall == 0);
    end else if (out_stall > 0) begin
      out_stall <= out_stall - 1;
      out_ready <= (out_stall == 1);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog: end the run if no word moves on either side for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        idle_cycles <= 0;
      end else if (idle_cycles >= IDLE_LIMIT) begin
        $display("FAILURE");
        $finish;
      end else begin
        idle_cycles <= idle_cycles + 1;
      end
    end
  end

  initial begin
    int push_pct;
    int pop_pct;
    int pick;

    // Directed: empty pops, removes of lone nodes, pushes at the node and
    // queue extremes, rejected pushes, removes at tail and middle, pops until
    // empty again, and the unused request code.
    add_word(REQ_POP, 0, 0);
    add_word(REQ_POP, 15, 3);
    add_word(REQ_REMOVE, 0, 3);
    add_word(REQ_REMOVE, 15, 0);
    add_word(REQ_PUSH, 0, 0);
    add_word(REQ_PUSH, 15, 0);
    add_word(REQ_PUSH, 5, 3);
    add_word(REQ_PUSH, 0, 3);
    add_word(REQ_PUSH, 15, 1);
    add_word(REQ_REMOVE, 15, 2);
    add_word(REQ_POP, 7, 0);
    add_word(REQ_POP, 0, 0);
    add_word(REQ_PUSH, 1, 2);
    add_word(REQ_PUSH, 2, 2);
    add_word(REQ_PUSH, 3, 2);
    add_word(REQ_REMOVE, 2, 1);
    add_word(REQ_POP, 10, 2);
    add_word(REQ_POP, 0, 2);
    add_word(REQ_POP, 0, 2);
    add_word(REQ_UNUSED, 15, 3);
    add_word(REQ_UNUSED, 0, 0);
    add_word(REQ_POP, 0, 3);
    add_word(REQ_POP, 15, 1);

    // Random: the request mix shifts every hundred words so the queues both
    // fill up (and push rejects) and drain (and pops run empty).
    push_pct = 50;
    pop_pct  = 25;
    for (int i = 0; i < RAND_WORDS; i++) begin
      if (i % 100 == 0) begin
        push_pct = $urandom_range(20, 70);
        pop_pct  = $urandom_range(10, 95 - push_pct);
      end
      pick = $urandom_range(0, 99);
      if (pick < 3) begin
        add_word(REQ_UNUSED, $urandom_range(0, 15), $urandom_range(0, 3));
      end else if (pick < 3 + push_pct) begin
        add_word(REQ_PUSH, $urandom_range(0, 15), $urandom_range(0, 3));
      end else if (pick < 3 + push_pct + pop_pct) begin
        add_word(REQ_POP, $urandom_range(0, 15), $urandom_range(0, 3));
      end else begin
        add_word(REQ_REMOVE, $urandom_range(0, 15), $urandom_range(0, 3));
      end
    end

    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Drain: every word taken, every result seen, then a short settle.
    // Sample away from the active edge so driver updates have landed.
    do begin
      @(negedge clk_i);
    end while (pending_words.size() != 0 || in_valid || expected_outcomes.size() != 0);
    repeat (12) @(posedge clk_i);

    if (error_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/llqm_pkg.sv
design/llqm_ctrl.sv
design/llqm_datapath.sv
design/linked_list_queue_manager_top.sv
tb/linked_list_queue_manager_top_tb.sv
